/* rtl/rgbu_pkg.sv */
`default_nettype none

package rgbu_pkg;

    // Source raster geometry.
    localparam int FRAME_WIDTH  = 240;
    localparam int FRAME_HEIGHT = 160;

    // One line-store entry per 2x2 block column, one block row per row pair.
    localparam int PAIR_COLS = FRAME_WIDTH / 2;
    localparam int PAIR_ROWS = FRAME_HEIGHT / 2;

    localparam int COL_W  = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
    localparam int ROW_W  = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;
    localparam int ADDR_W = (PAIR_COLS > 1) ? $clog2(PAIR_COLS) : 1;

    localparam int PIX_W = 16;
    localparam int IDX_W = 7;

    // Drops the low bit of each 5-bit channel and the flag, so the shift cannot carry a bit
    // into the channel below.
    localparam logic [PIX_W-1:0] CHAN_MASK = 16'h7bde;

    typedef logic [PIX_W-1:0] t_pixel;
    typedef logic [IDX_W-1:0] t_index;

    typedef struct packed {
        t_pixel     top_left;
        t_pixel     top_mid;
        t_pixel     top_right;
        t_pixel     mid_left;
        t_pixel     center;
        t_pixel     mid_right;
        t_pixel     bottom_left;
        t_pixel     bottom_mid;
        t_pixel     bottom_right;
        t_index     block_col;
        t_index     block_row;
        logic       frame_done;
    } t_block;

    // Per-channel floor average; the flag bit comes out as the AND of both flags.
    function automatic t_pixel blend(input t_pixel a, input t_pixel b);
        t_pixel diff;
        diff = (a ^ b) & CHAN_MASK;
        return (a & b) + (diff >> 1);
    endfunction

endpackage

`default_nettype wire

/* rtl/rgbu_pix_if.sv */
`default_nettype none

interface rgbu_pix_if;
    logic               valid;
    logic               ready;
    rgbu_pkg::t_pixel   pixel;
    logic               frame_start;

    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

`default_nettype wire

/* rtl/rgbu_blk_if.sv */
`default_nettype none

interface rgbu_blk_if;
    logic               valid;
    logic               ready;
    rgbu_pkg::t_pixel   top_left;
    rgbu_pkg::t_pixel   top_mid;
    rgbu_pkg::t_pixel   top_right;
    rgbu_pkg::t_pixel   mid_left;
    rgbu_pkg::t_pixel   center;
    rgbu_pkg::t_pixel   mid_right;
    rgbu_pkg::t_pixel   bottom_left;
    rgbu_pkg::t_pixel   bottom_mid;
    rgbu_pkg::t_pixel   bottom_right;
    rgbu_pkg::t_index   block_col;
    rgbu_pkg::t_index   block_row;
    logic               frame_done;

    modport source (
        output valid, output top_left, output top_mid, output top_right,
        output mid_left, output center, output mid_right,
        output bottom_left, output bottom_mid, output bottom_right,
        output block_col, output block_row, output frame_done,
        input ready
    );
    modport sink (
        input valid, input top_left, input top_mid, input top_right,
        input mid_left, input center, input mid_right,
        input bottom_left, input bottom_mid, input bottom_right,
        input block_col, input block_row, input frame_done,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/rgb555_upscale_3_over_2.sv */
`default_nettype none

// 1.5x averaging upscaler for RGB555 raster streams. Pixels enter one per item in raster
// order, FRAME_WIDTH per row and FRAME_HEIGHT rows per frame; a frame_start item forces the
// position back to row 0, column 0, and the position also wraps by itself after the last
// pixel. Each 2x2 source block leaves as one item carrying a 3x3 block: the corners are the
// source pixels, the edge midpoints are per-channel floor averages with the flag bits ANDed,
// and the center is the average of the two vertical midpoints. A trailing odd column or row
// is consumed and dropped. The block takes one pixel every clock cycle; the only limit is
// the output side, and a block stalls its input only when both its blend stage and its
// output register are full. A finished block is registered in the blend stage, then in the
// output register. The even row is kept in a line store of two single-port-style memories
// with a registered read, one for even-column and one for odd-column pixels. The store is
// not cleared at reset; every entry is written by an even row before an odd row reads it.

module rgb555_upscale_3_over_2 (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    rgbu_pix_if.sink     i_pix,
    rgbu_blk_if.source   o_blk
);
    import rgbu_pkg::*;

    // Raster position of the next pixel.
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;

    // Even-column pixel of the current odd row, waiting for its partner.
    t_pixel            r_held;

    // Line store for the even row of each block row, split by column parity.
    t_pixel            r_lo_mem [PAIR_COLS];
    t_pixel            r_hi_mem [PAIR_COLS];
    t_pixel            r_top_lo;
    t_pixel            r_top_hi;

    // Blend stage: the bottom pair and block position, with the top pair from the store.
    logic              r_s2_valid;
    t_pixel            r_s2_bl;
    t_pixel            r_s2_br;
    t_index            r_s2_col;
    t_index            r_s2_row;
    logic              r_s2_done;

    // Output register.
    logic              r_out_valid;
    t_block            r_out;

    logic              out_adv;
    logic              s2_adv;
    logic              pix_acc;
    logic [COL_W-1:0]  cur_col;
    logic [ROW_W-1:0]  cur_row;
    logic [COL_W-1:0]  bc;
    logic [ROW_W-1:0]  br;
    logic [31:0]       bc_wide;
    logic [31:0]       br_wide;
    logic              in_range;
    logic [ADDR_W-1:0] addr;
    logic              wr_lo;
    logic              wr_hi;
    logic              rd_en;
    logic              emit;
    logic              last_col;
    logic              last_row;
    t_pixel            mid_l;
    t_pixel            mid_r;
    t_block            n_blk;

    // The output register takes a new block when it is empty or being emptied; the blend
    // stage may refill in the same cycle it hands its block on.
    assign out_adv     = !r_out_valid || o_blk.ready;
    assign s2_adv      = r_s2_valid && out_adv;
    assign i_pix.ready = !r_s2_valid || out_adv;
    assign pix_acc     = i_pix.valid && i_pix.ready;

    // Position of the pixel being offered, after any restart.
    always_comb begin
        cur_col  = i_pix.frame_start ? '0 : r_col;
        cur_row  = i_pix.frame_start ? '0 : r_row;
        bc       = cur_col >> 1;
        br       = cur_row >> 1;
        bc_wide  = 32'(bc);
        br_wide  = 32'(br);
        in_range = (bc_wide < 32'(PAIR_COLS)) && (br_wide < 32'(PAIR_ROWS));
        addr     = bc[ADDR_W-1:0];

        wr_lo = pix_acc && in_range && !cur_row[0] && !cur_col[0];
        wr_hi = pix_acc && in_range && !cur_row[0] &&  cur_col[0];
        // The top pair is fetched when the even-column pixel of the odd row arrives, so
        // it is waiting in the read register when the block completes.
        rd_en = pix_acc && in_range &&  cur_row[0] && !cur_col[0];
        emit  = pix_acc && in_range &&  cur_row[0] &&  cur_col[0];

        last_col = (32'(cur_col) == 32'(FRAME_WIDTH - 1));
        last_row = (32'(cur_row) == 32'(FRAME_HEIGHT - 1));
        n_col    = last_col ? '0 : cur_col + 1'b1;
        n_row    = last_col ? (last_row ? '0 : cur_row + 1'b1) : cur_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_held <= '0;
        end else if (pix_acc) begin
            r_col <= n_col;
            r_row <= n_row;
            if (rd_en) begin
                r_held <= i_pix.pixel;
            end
        end
    end

    // Writes happen only on even rows and reads only on odd rows, so a single item never
    // touches the same entry twice; the read register holds until the next fetch, which
    // the input stall keeps from landing while a block still waits in the blend stage.
    always_ff @(posedge i_clk) begin
        if (wr_lo) begin
            r_lo_mem[addr] <= i_pix.pixel;
        end
        if (wr_hi) begin
            r_hi_mem[addr] <= i_pix.pixel;
        end
        if (rd_en) begin
            r_top_lo <= r_lo_mem[addr];
            r_top_hi <= r_hi_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (emit) begin
            r_s2_valid <= 1'b1;
        end else if (s2_adv) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_s2_bl   <= r_held;
            r_s2_br   <= i_pix.pixel;
            r_s2_col  <= bc_wide[IDX_W-1:0];
            r_s2_row  <= br_wide[IDX_W-1:0];
            r_s2_done <= (bc_wide == 32'(PAIR_COLS - 1)) && (br_wide == 32'(PAIR_ROWS - 1));
        end
    end

    // Blends: vertical midpoints first, the center from those two.
    always_comb begin
        mid_l = blend(r_top_lo, r_s2_bl);
        mid_r = blend(r_top_hi, r_s2_br);

        n_blk.top_left     = r_top_lo;
        n_blk.top_mid      = blend(r_top_lo, r_top_hi);
        n_blk.top_right    = r_top_hi;
        n_blk.mid_left     = mid_l;
        n_blk.center       = blend(mid_l, mid_r);
        n_blk.mid_right    = mid_r;
        n_blk.bottom_left  = r_s2_bl;
        n_blk.bottom_mid   = blend(r_s2_bl, r_s2_br);
        n_blk.bottom_right = r_s2_br;
        n_blk.block_col    = r_s2_col;
        n_blk.block_row    = r_s2_row;
        n_blk.frame_done   = r_s2_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_blk.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_adv) begin
            r_out <= n_blk;
        end
    end

    assign o_blk.valid        = r_out_valid;
    assign o_blk.top_left     = r_out.top_left;
    assign o_blk.top_mid      = r_out.top_mid;
    assign o_blk.top_right    = r_out.top_right;
    assign o_blk.mid_left     = r_out.mid_left;
    assign o_blk.center       = r_out.center;
    assign o_blk.mid_right    = r_out.mid_right;
    assign o_blk.bottom_left  = r_out.bottom_left;
    assign o_blk.bottom_mid   = r_out.bottom_mid;
    assign o_blk.bottom_right = r_out.bottom_right;
    assign o_blk.block_col    = r_out.block_col;
    assign o_blk.block_row    = r_out.block_row;
    assign o_blk.frame_done   = r_out.frame_done;

    // A new fetch must never overwrite the top pair of a block still held in the blend stage.
    a_no_fetch_over_pending: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !out_adv) |-> !rd_en
    ) else $error("line store fetch while a block is pending");

    // A completing pixel always fills the blend stage on the next cycle.
    a_emit_fills_stage: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        emit |=> r_s2_valid
    ) else $error("completed block did not reach the blend stage");

    // A block leaving the blend stage is visible at the output on the next cycle.
    a_stage_to_output: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        s2_adv |=> r_out_valid
    ) else $error("block lost between blend stage and output");

endmodule

`default_nettype wire
